/* design/sitoa_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
package sitoa_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int CHAR_WIDTH = 6;

    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic negative;
        logic out_free;
    } status_t;

endpackage

/* design/signed_int_to_decimal_ascii_top.sv */
// Top level of the signed integer to decimal ASCII text converter.
//
// Each input transfer carries one signed VALUE_WIDTH-bit integer; the block sends its
// decimal text, most significant character first, one character per output transfer,
// with a leading '-' for negative values, no leading zeros, '0' for zero and tlast on
// the final character. The magnitude goes through a shift-and-add-3 BCD converter one
// bit per cycle. An item is then handled in order: accept, conversion, one shift per
// suppressed leading zero, the sign if negative and one output transfer per digit,
// where the BCD register holds D digits (10 at VALUE_WIDTH 32). Output back-pressure
// stalls the sign and digit steps. The next item is taken while the last character
// still waits in the output register.
module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = sitoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // character
    output logic                                m_tlast
);

    sitoa_pkg::cmd_t                  cmd;
    sitoa_pkg::status_t               status;
    logic [sitoa_pkg::CHAR_WIDTH-1:0] character;

    sitoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sitoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s_tdata[VALUE_WIDTH-1:0]),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(8 - sitoa_pkg::CHAR_WIDTH){1'b0}}, character};

endmodule

/* design/sitoa_ctrl.sv */
// Control state machine: sequences load, conversion, zero skip and character output.
module sitoa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output sitoa_pkg::cmd_t   cmd,
    input  sitoa_pkg::status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (status.conv_done) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (status.top_zero && !status.one_left) begin
                    cmd.skip_step = 1'b1;
                end else if (status.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.one_left) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/sitoa_dp.sv */
// Datapath: magnitude, shift-and-add-3 BCD converter, digit shifter and output register.
module sitoa_dp #(
    parameter int VALUE_WIDTH = sitoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [VALUE_WIDTH-1:0]         value,
    input  sitoa_pkg::cmd_t                cmd,
    output sitoa_pkg::status_t             status,
    output logic [sitoa_pkg::CHAR_WIDTH-1:0] character,
    output logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready
);

    localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCDW  = 4 * NDIG;
    localparam int BCW   = $clog2(VALUE_WIDTH + 1);
    localparam int DCW   = $clog2(NDIG + 1);

    logic [VALUE_WIDTH-1:0]             mag_reg, mag_next;
    logic [BCDW-1:0]                    bcd_reg, bcd_next;
    logic [BCDW-1:0]                    bcd_adj;
    logic [BCW-1:0]                     bitcnt_reg, bitcnt_next;
    logic [DCW-1:0]                     dcnt_reg, dcnt_next;
    logic                               neg_reg, neg_next;
    logic [sitoa_pkg::CHAR_WIDTH-1:0]   char_reg, char_next;
    logic                               last_reg, last_next;
    logic                               valid_reg, valid_next;
    logic [3:0]                         top_digit;

    assign top_digit = bcd_reg[BCDW-1 -: 4];

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        dcnt_next   = dcnt_reg;
        neg_next    = neg_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        valid_next  = valid_reg;

        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end

        if (cmd.load) begin
            neg_next    = value[VALUE_WIDTH-1];
            mag_next    = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
            bcd_next    = '0;
            bitcnt_next = BCW'(VALUE_WIDTH);
            dcnt_next   = DCW'(NDIG);
        end

        if (cmd.conv_step) begin
            bcd_next    = {bcd_adj[BCDW-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next    = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bitcnt_next = bitcnt_reg - 1'b1;
        end

        if (cmd.skip_step) begin
            bcd_next  = {bcd_reg[BCDW-5:0], 4'd0};
            dcnt_next = dcnt_reg - 1'b1;
        end

        if (cmd.emit_sign) begin
            char_next  = sitoa_pkg::CHAR_MINUS;
            last_next  = 1'b0;
            valid_next = 1'b1;
        end else if (cmd.emit_digit) begin
            char_next  = sitoa_pkg::CHAR_ZERO + {2'b00, top_digit};
            last_next  = (dcnt_reg == DCW'(1));
            valid_next = 1'b1;
            bcd_next   = {bcd_reg[BCDW-5:0], 4'd0};
            dcnt_next  = dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        mag_reg    <= mag_next;
        bcd_reg    <= bcd_next;
        bitcnt_reg <= bitcnt_next;
        dcnt_reg   <= dcnt_next;
        neg_reg    <= neg_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign status.conv_done = (bitcnt_reg == BCW'(1));
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.one_left  = (dcnt_reg == DCW'(1));
    assign status.negative  = neg_reg;
    assign status.out_free  = !valid_reg || out_ready;

    assign character = char_reg;
    assign last      = last_reg;
    assign out_valid = valid_reg;

endmodule
